/* design/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg: shared types for the sorted set
// Request codes, channel payloads and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package ssi_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic                stored;
        logic                dropped_full;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    // One request in flight along the chain.
    typedef struct packed {
        logic                       active;
        logic [1:0]                 kind;
        logic                       live;   // insert still carrying a value
        logic                       full;   // set was full at acceptance
        logic                       found;
        logic                       stored;
        logic signed [VALUE_W-1:0]  value;  // carried value
    } t_token;

endpackage

/* design/ssi_cell.sv */
// ----------------------------------------------------------------------------
// ssi_cell: one compare-and-shift cell of the sorted set
// Holds one entry, matches the passing token against it and, on insert,
// swaps in the smaller value, handing the larger one to the next cell.
// ----------------------------------------------------------------------------
module ssi_cell #(
    parameter int unsigned CNT_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssi_pkg::t_token       i_tok,
    input  logic [CNT_W-1:0]      i_rem,
    output ssi_pkg::t_token       o_tok,
    output logic [CNT_W-1:0]      o_rem
);
    import ssi_pkg::*;

    logic signed [VALUE_W-1:0]  r_entry;
    logic signed [VALUE_W-1:0]  n_entry;
    t_token                     r_tok;
    t_token                     n_tok;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W-1:0]           n_rem;
    logic                       w_occupied;
    logic                       w_write;

    // Entries ahead of the token still to be visited.
    assign w_occupied = (i_rem != '0);
    assign n_rem      = w_occupied ? i_rem - 1'b1 : '0;

    always_comb begin
        n_tok   = i_tok;
        n_entry = r_entry;
        w_write = 1'b0;
        if (i_tok.active && w_occupied) begin
            if (r_entry == i_tok.value) begin
                n_tok.found = 1'b1;
                n_tok.live  = 1'b0;
            end else if (i_tok.live && (r_entry > i_tok.value)) begin
                // swap: keep the smaller value, pass the larger one on
                w_write     = 1'b1;
                n_entry     = i_tok.value;
                n_tok.value = r_entry;
            end
        end else if (i_tok.active && i_tok.live) begin
            // first free cell: drop the carried value here
            w_write      = 1'b1;
            n_entry      = i_tok.value;
            n_tok.live   = 1'b0;
            n_tok.stored = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_entry <= n_entry;
        end
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_rem = r_rem;

endmodule

/* design/sorted_set_insert_query.sv */
// ----------------------------------------------------------------------------
// sorted_set_insert_query: sorted set of distinct signed values
// A token visits each cell of the chain in turn. The block takes one
// request at a time: the next request enters the cycle after the
// result is taken.
// Reset clears the entry count and all control; entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_set_insert_query #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ssi_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ssi_pkg::t_out_item  o_out_item
);
    import ssi_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    t_token             w_tok [CAPACITY+1];
    logic [CNT_W-1:0]   w_rem [CAPACITY+1];
    t_token             w_head;
    logic               w_in_xfer;
    logic               w_out_xfer;
    t_token             w_end;
    logic               r_busy;
    logic               n_busy;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    always_comb begin
        w_head        = '0;
        w_head.active = w_in_xfer;
        w_head.kind   = i_in_item.req_type;
        w_head.full   = (r_count == CNT_W'(CAPACITY));
        w_head.live   = (i_in_item.req_type == REQ_INSERT) &&
                        (r_count != CNT_W'(CAPACITY));
        w_head.value  = i_in_item.value;
    end

    assign w_tok[0] = w_head;
    assign w_rem[0] = r_count;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ssi_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_rem   (w_rem[g]),
            .o_tok   (w_tok[g+1]),
            .o_rem   (w_rem[g+1])
        );
    end

    assign w_end = w_tok[CAPACITY];

    always_comb begin
        n_count = r_count;
        if (w_end.active) begin
            if (w_end.stored) begin
                n_count = r_count + 1'b1;
            end else if (w_end.kind == REQ_CLEAR) begin
                n_count = '0;
            end
        end
    end

    always_comb begin
        n_out_item              = r_out_item;
        n_out_valid             = r_out_valid && !w_out_xfer;
        if (w_end.active) begin
            n_out_valid              = 1'b1;
            n_out_item.found         = w_end.found;
            n_out_item.stored        = w_end.stored;
            n_out_item.dropped_full  = (w_end.kind == REQ_INSERT) && w_end.full &&
                                       !w_end.found;
            n_out_item.entry_count   = COUNT_W'(n_count);
        end
    end

    // Hold off new transfers until the result has left.
    always_comb begin
        n_busy = r_busy;
        if (w_in_xfer) begin
            n_busy = 1'b1;
        end else if (w_out_xfer) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_token_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.active |-> r_busy)
        else $error("token left the chain with no request in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.stored && (r_out_item.dropped_full ||
                          r_out_item.found)))
        else $error("inconsistent result flags");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result valid while idle");
`endif

endmodule

/* test/tb_sorted_set_insert_query.sv */
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_query: self-checking bench for the sorted set
// Drives insert, query, clear and unnamed-code requests over the valid/stall
// input channel, predicts each result from a local copy of the set, and
// compares every result transfer field by field. Directed cases cover the
// value extremes, duplicates, a full set and clears. Random traffic follows,
// run under three idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_query;
    import ssi_pkg::*;

    localparam int unsigned CAPACITY  = 16;
    localparam int unsigned SET_IDX_W = $clog2(CAPACITY);
    localparam int unsigned EXP_DEPTH = 64;
    // The request field has one code that the package leaves unnamed.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;

    // Local copy of the set, in ascending signed order.
    logic signed [VALUE_W-1:0] set_values [CAPACITY];
    int unsigned               set_size;

    // Ring of predicted results, written on input transfer, read on result.
    t_out_item   expected_results [EXP_DEPTH];
    int unsigned exp_wr_count;
    int unsigned exp_rd_count;
    int          failures;
    int          send_idle_pct;
    int          recv_stall_pct;

    sorted_set_insert_query #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Apply one request to the local set and return the result it gives.
    function automatic t_out_item predict_set(t_in_item req);
        t_out_item                 res;
        logic signed [VALUE_W-1:0] val;
        int unsigned               pos;
        logic                      hit;
        val = req.value;
        pos = 0;
        hit = 1'b0;
        res = '0;
        for (int unsigned i = 0; i < set_size; i++) begin
            if (set_values[SET_IDX_W'(i)] < val)
                pos = i + 1;
            else if (set_values[SET_IDX_W'(i)] == val)
                hit = 1'b1;
        end
        if (req.req_type == REQ_INSERT && !hit) begin
            if (set_size >= CAPACITY) begin
                res.dropped_full = 1'b1;
            end else begin
                for (int unsigned i = set_size; i > pos; i--)
                    set_values[SET_IDX_W'(i)] = set_values[SET_IDX_W'(i-1)];
                set_values[SET_IDX_W'(pos)] = val;
                set_size++;
                res.stored = 1'b1;
            end
        end else if (req.req_type == REQ_CLEAR) begin
            set_size = 0;
        end
        res.found       = hit;
        res.entry_count = set_size[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr_count == exp_rd_count) begin
                $error("result transfer with no request outstanding: %p", o_out_item);
                failures++;
            end else begin
                want = expected_results[exp_rd_count[5:0]];
                exp_rd_count++;
                if (o_out_item.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_item.found);
                    failures++;
                end
                if (o_out_item.stored !== want.stored) begin
                    $error("stored: expected %0d, got %0d", want.stored, o_out_item.stored);
                    failures++;
                end
                if (o_out_item.dropped_full !== want.dropped_full) begin
                    $error("dropped_full: expected %0d, got %0d",
                           want.dropped_full, o_out_item.dropped_full);
                    failures++;
                end
                if (o_out_item.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_out_item.entry_count);
                    failures++;
                end
            end
        end
    end

    // Offer one request and hold it until the transfer happens.
    task automatic send_request(input logic [1:0] kind, input logic signed [VALUE_W-1:0] val);
        t_in_item req;
        req.req_type = kind;
        req.value    = val;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results[exp_wr_count[5:0]] = predict_set(req);
        exp_wr_count++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr_count != exp_rd_count) @(posedge i_clk);
        repeat (CAPACITY + 4) @(posedge i_clk);
    endtask

    task automatic test_basic_ops();
        send_request(REQ_INSERT, VALUE_MIN);
        send_request(REQ_INSERT, VALUE_MAX);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_QUERY, 32'sd1);
        send_request(REQ_QUERY, VALUE_MAX);
        send_request(REQ_UNUSED, VALUE_MIN);
        send_request(REQ_UNUSED, 32'sd5);
        send_request(REQ_CLEAR, 32'sd0);
        send_request(REQ_QUERY, VALUE_MIN);
        send_request(REQ_CLEAR, 32'sd7);
    endtask

    task automatic test_full_set();
        int k;
        // Fill in scrambled order so that entries shift on most inserts.
        for (int i = 0; i < CAPACITY; i++) begin
            k = (i * 7) % CAPACITY;
            send_request(REQ_INSERT, k * 1000 - 8000);
        end
        send_request(REQ_INSERT, 32'sd123);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_QUERY, 32'sd123);
        send_request(REQ_CLEAR, -32'sd8000);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        int unsigned               r;
        r = $urandom_range(99);
        if (r < 60) begin
            // Small pool: duplicates and full sets turn up often.
            v = $urandom_range(23);
            v = v - 32'sd12;
        end else if (r < 66) begin
            v = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int unsigned r;
        logic [1:0]  kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (r < 55)
                kind = REQ_INSERT;
            else if (r < 91)
                kind = REQ_QUERY;
            else if (r < 97)
                kind = REQ_UNUSED;
            else
                kind = REQ_CLEAR;
            send_request(kind, pick_value());
        end
        wait_for_results();
    endtask

    initial begin
        failures       = 0;
        set_size       = 0;
        exp_wr_count   = 0;
        exp_rd_count   = 0;
        send_idle_pct  = 9;
        recv_stall_pct = 68;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_full_set();
        wait_for_results();
        test_random_traffic(380, 9, 68);
        test_random_traffic(380, 68, 9);
        test_random_traffic(380, 0, 0);

        if (failures == 0)
            $display("sorted_set_insert_query: match");
        else
            $display("sorted_set_insert_query: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_set_insert_query: mismatch");
        $finish;
    end

endmodule
